FILE: sv/aabb_frustum_cull_unit_assert.svh
// Assertion macros for the frustum cull unit.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef AABB_FRUSTUM_CULL_UNIT_ASSERT_SVH
`define AABB_FRUSTUM_CULL_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFC_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFC_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/afc_pkg.sv
package afc_pkg;

    localparam int NUM_CFG     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ENTRY_W     = 32;
    localparam int COORD_W     = 16;
    localparam int NUM_AXES    = 3;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_PLANES  = 6;

    typedef logic [NUM_PLANES-1:0] plane_mask_t;
    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    // Reset state is the identity matrix in Q16.16.
    localparam cfg_word_t CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

FILE: sv/aabb_frustum_cull_unit.sv
// Frustum cull unit: tests one grid cube against the six clip planes of a
// configured view-projection matrix (Q16.16 entries, two per 64-bit register).
// Input channel (in_valid/in_ready) carries one cube coordinate per word; the
// output channel (out_valid/out_ready) returns the six-plane reject mask and a
// visible flag, one word for each input word, in order.
// Each accepted word passes through the six-stage datapath (corner scale,
// matrix multiply, row sum, plane base, corner offset compare, reject
// reduce) and is then presented with out_valid. Throughput is one word per
// cycle while the receiver keeps out_ready high.
// Each stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up when the receiver stalls and
// in_ready drops only once all six stages hold a word.
// The matrix registers are written through cfg_we/cfg_index/cfg_data with
// no wait. Per-axis corner offsets are derived from the matrix in a
// three-stage side pipeline, so a word accepted from the cycle after a write
// on sees the new matrix.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the
// identity matrix.
`include "aabb_frustum_cull_unit_assert.svh"

module aabb_frustum_cull_unit #(
    parameter int CUBE_SIZE = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [afc_pkg::COORD_W-1:0]  cube_x,
    input  logic signed [afc_pkg::COORD_W-1:0]  cube_y,
    input  logic signed [afc_pkg::COORD_W-1:0]  cube_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                visible,
    output logic [afc_pkg::NUM_PLANES-1:0]      plane_reject_mask
);

    localparam int SIZE_W = $clog2(CUBE_SIZE + 1);
    localparam int PW     = afc_pkg::COORD_W + SIZE_W + 1;
    localparam int MW     = afc_pkg::ENTRY_W + PW;
    localparam int CLW    = MW + 2;
    localparam int UW     = CLW + 1;
    localparam int DW     = afc_pkg::ENTRY_W + SIZE_W + 1;
    localparam int OW     = DW + 3;
    localparam int STAGES = 6;

    localparam logic signed [SIZE_W:0] SIZE_S = (SIZE_W + 1)'(CUBE_SIZE);

    // ---------------------------------------------------------------------
    // Matrix registers
    // ---------------------------------------------------------------------
    afc_pkg::cfg_word_t cfg_reg [afc_pkg::NUM_CFG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= afc_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    logic signed [afc_pkg::ENTRY_W-1:0] m [afc_pkg::NUM_ROWS][afc_pkg::NUM_ROWS];

    for (genvar r = 0; r < afc_pkg::NUM_ROWS; r++)
    begin : g_unpack_row
        for (genvar c = 0; c < afc_pkg::NUM_ROWS; c++)
        begin : g_unpack_col
            assign m[r][c] =
                cfg_reg[2 * r + c / 2][afc_pkg::ENTRY_W * (c % 2) +: afc_pkg::ENTRY_W];
        end
    end

    // ---------------------------------------------------------------------
    // Corner offsets derived from the matrix. Moving one corner by one cube
    // size along an axis changes each clip term by M[r][axis] * size, so the
    // plane sums of corner k are those of the low corner plus fixed offsets.
    // ---------------------------------------------------------------------
    logic signed [DW-1:0] dm_next [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES];
    logic signed [DW-1:0] dm_reg  [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES];
    logic signed [DW:0]   du_next [afc_pkg::NUM_AXES][afc_pkg::NUM_AXES];
    logic signed [DW:0]   du_reg  [afc_pkg::NUM_AXES][afc_pkg::NUM_AXES];
    logic signed [DW:0]   dv_next [afc_pkg::NUM_AXES][afc_pkg::NUM_AXES];
    logic signed [DW:0]   dv_reg  [afc_pkg::NUM_AXES][afc_pkg::NUM_AXES];
    logic signed [OW-1:0] offu_next [afc_pkg::NUM_AXES][afc_pkg::NUM_CORNERS];
    logic signed [OW-1:0] offu_reg  [afc_pkg::NUM_AXES][afc_pkg::NUM_CORNERS];
    logic signed [OW-1:0] offv_next [afc_pkg::NUM_AXES][afc_pkg::NUM_CORNERS];
    logic signed [OW-1:0] offv_reg  [afc_pkg::NUM_AXES][afc_pkg::NUM_CORNERS];

    for (genvar r = 0; r < afc_pkg::NUM_ROWS; r++)
    begin : g_dm_row
        for (genvar c = 0; c < afc_pkg::NUM_AXES; c++)
        begin : g_dm_col
            assign dm_next[r][c] = DW'(m[r][c]) * DW'(SIZE_S);

            always_ff @(posedge clk)
            begin
                dm_reg[r][c] <= dm_next[r][c];
            end
        end
    end

    for (genvar a = 0; a < afc_pkg::NUM_AXES; a++)
    begin : g_off_plane
        for (genvar c = 0; c < afc_pkg::NUM_AXES; c++)
        begin : g_d_axis
            assign du_next[a][c] = (DW + 1)'(dm_reg[a][c]) + (DW + 1)'(dm_reg[3][c]);
            assign dv_next[a][c] = (DW + 1)'(dm_reg[a][c]) - (DW + 1)'(dm_reg[3][c]);

            always_ff @(posedge clk)
            begin
                du_reg[a][c] <= du_next[a][c];
                dv_reg[a][c] <= dv_next[a][c];
            end
        end

        for (genvar k = 0; k < afc_pkg::NUM_CORNERS; k++)
        begin : g_off_corner
            assign offu_next[a][k] =
                (((k & 1) != 0) ? OW'(du_reg[a][0]) : {OW{1'b0}}) +
                (((k & 2) != 0) ? OW'(du_reg[a][1]) : {OW{1'b0}}) +
                (((k & 4) != 0) ? OW'(du_reg[a][2]) : {OW{1'b0}});
            assign offv_next[a][k] =
                (((k & 1) != 0) ? OW'(dv_reg[a][0]) : {OW{1'b0}}) +
                (((k & 2) != 0) ? OW'(dv_reg[a][1]) : {OW{1'b0}}) +
                (((k & 4) != 0) ? OW'(dv_reg[a][2]) : {OW{1'b0}});

            always_ff @(posedge clk)
            begin
                offu_reg[a][k] <= offu_next[a][k];
                offv_reg[a][k] <= offv_next[a][k];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control
    // ---------------------------------------------------------------------
    logic [STAGES-1:0] stage_valid_reg;
    logic [STAGES-1:0] stage_valid_next;
    logic [STAGES-1:0] stage_en;

    assign stage_en[STAGES-1]         = !stage_valid_reg[STAGES-1] || out_ready;
    assign stage_valid_next[0]        = in_valid;

    for (genvar i = 0; i < STAGES - 1; i++)
    begin : g_ctrl
        assign stage_en[i]             = !stage_valid_reg[i] || stage_en[i+1];
        assign stage_valid_next[i+1]   = stage_valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (stage_en[i])
                begin
                    stage_valid_reg[i] <= stage_valid_next[i];
                end
            end
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = stage_valid_reg[STAGES-1];

    // ---------------------------------------------------------------------
    // Stage 1: low corner of the cube on each axis
    // ---------------------------------------------------------------------
    logic signed [afc_pkg::COORD_W-1:0] coord [afc_pkg::NUM_AXES];
    logic signed [PW-1:0] lo_next [afc_pkg::NUM_AXES];
    logic signed [PW-1:0] lo_reg  [afc_pkg::NUM_AXES];

    assign coord[0] = cube_x;
    assign coord[1] = cube_y;
    assign coord[2] = cube_z;

    for (genvar a = 0; a < afc_pkg::NUM_AXES; a++)
    begin : g_s1
        assign lo_next[a] = PW'(coord[a]) * PW'(SIZE_S);

        always_ff @(posedge clk)
        begin
            if (stage_en[0])
            begin
                lo_reg[a] <= lo_next[a];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: matrix entries times low corner
    // ---------------------------------------------------------------------
    logic signed [MW-1:0] prod_next [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES];
    logic signed [MW-1:0] prod_reg  [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES];

    for (genvar r = 0; r < afc_pkg::NUM_ROWS; r++)
    begin : g_s2_row
        for (genvar c = 0; c < afc_pkg::NUM_AXES; c++)
        begin : g_s2_col
            assign prod_next[r][c] = MW'(m[r][c]) * MW'(lo_reg[c]);

            always_ff @(posedge clk)
            begin
                if (stage_en[1])
                begin
                    prod_reg[r][c] <= prod_next[r][c];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: clip point of the low corner
    // ---------------------------------------------------------------------
    logic signed [CLW-1:0] base_next [afc_pkg::NUM_ROWS];
    logic signed [CLW-1:0] base_reg  [afc_pkg::NUM_ROWS];

    for (genvar r = 0; r < afc_pkg::NUM_ROWS; r++)
    begin : g_s3
        assign base_next[r] = CLW'(prod_reg[r][0]) + CLW'(prod_reg[r][1])
                            + CLW'(prod_reg[r][2]) + CLW'(m[r][3]);

        always_ff @(posedge clk)
        begin
            if (stage_en[2])
            begin
                base_reg[r] <= base_next[r];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: plane sums of the low corner, c + w and c - w per axis
    // ---------------------------------------------------------------------
    logic signed [UW-1:0] bu_next [afc_pkg::NUM_AXES];
    logic signed [UW-1:0] bu_reg  [afc_pkg::NUM_AXES];
    logic signed [UW-1:0] bv_next [afc_pkg::NUM_AXES];
    logic signed [UW-1:0] bv_reg  [afc_pkg::NUM_AXES];

    for (genvar a = 0; a < afc_pkg::NUM_AXES; a++)
    begin : g_s4
        assign bu_next[a] = UW'(base_reg[a]) + UW'(base_reg[3]);
        assign bv_next[a] = UW'(base_reg[a]) - UW'(base_reg[3]);

        always_ff @(posedge clk)
        begin
            if (stage_en[3])
            begin
                bu_reg[a] <= bu_next[a];
                bv_reg[a] <= bv_next[a];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: per-corner outside flags. Points on a plane count as inside.
    // ---------------------------------------------------------------------
    logic [afc_pkg::NUM_CORNERS-1:0][afc_pkg::NUM_PLANES-1:0] outside_next;
    logic [afc_pkg::NUM_CORNERS-1:0][afc_pkg::NUM_PLANES-1:0] outside_reg;

    for (genvar k = 0; k < afc_pkg::NUM_CORNERS; k++)
    begin : g_s5_corner
        for (genvar a = 0; a < afc_pkg::NUM_AXES; a++)
        begin : g_s5_axis
            logic signed [UW-1:0] cu;
            logic signed [UW-1:0] cv;

            assign cu = bu_reg[a] + UW'(offu_reg[a][k]);
            assign cv = bv_reg[a] + UW'(offv_reg[a][k]);

            assign outside_next[k][2*a]   = cu[UW-1];
            assign outside_next[k][2*a+1] = !cv[UW-1] && (cv != {UW{1'b0}});
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            outside_reg <= outside_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 6: a plane rejects the cube when every corner is outside it
    // ---------------------------------------------------------------------
    afc_pkg::plane_mask_t mask_next;
    afc_pkg::plane_mask_t mask_reg;
    logic                 visible_reg;

    always_comb
    begin
        mask_next = {afc_pkg::NUM_PLANES{1'b1}};
        for (int k = 0; k < afc_pkg::NUM_CORNERS; k++)
        begin
            mask_next = mask_next & outside_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            mask_reg    <= mask_next;
            visible_reg <= (mask_next == '0);
        end
    end

    assign plane_reject_mask = mask_reg;
    assign visible           = visible_reg;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `AFC_CHECK_NOW(a_full_when_blocked, !in_ready, &stage_valid_reg,
        "input blocked while a pipeline stage is empty")
    `AFC_CHECK_NEXT(a_accept_enters, in_valid && in_ready, stage_valid_reg[0],
        "accepted word did not enter the first stage")
    `AFC_CHECK_NEXT(a_held_flags, stage_valid_reg[4] && !stage_en[4],
        stage_valid_reg[4] && $stable(outside_reg),
        "stalled corner flags changed")

endmodule
